// ===== hdl/sbte_pkg.sv =====
// Shared types and constants for the servo bus transaction engine.
// No dependencies; every other file in hdl/ refers to this package.
package sbte_pkg;

  // Operation codes of an input transaction
  localparam logic [2:0] OP_READ     = 3'd0;
  localparam logic [2:0] OP_WR_BYTE  = 3'd1;
  localparam logic [2:0] OP_WR_WORD  = 3'd2;
  localparam logic [2:0] OP_RX_BYTE  = 3'd3;
  localparam logic [2:0] OP_IDLE_TICK = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_READ_OPCODE  = 2'd0;
  localparam logic [1:0] CFG_WRITE_OPCODE = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

  localparam logic [7:0]  READ_OPCODE_RST  = 8'd2;
  localparam logic [7:0]  WRITE_OPCODE_RST = 8'd3;
  localparam logic [15:0] TIMEOUT_RST      = 16'd1000;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;

  localparam int RX_BUFFER_BYTES_DEF = 256;
  localparam int JOB_Q_DEPTH         = 4;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  servo_id;
    logic [7:0]  reg_addr;
    logic [7:0]  read_len;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [7:0]  status_error;
    logic [15:0] read_value;
  } out_item_t;

  // Work handed from the front to the back: either a frame to send
  // (header FF FF, body bytes, checksum) or a single read result.
  typedef struct packed {
    logic            is_result;
    logic            word_frame;   // six body bytes instead of five
    logic [5:0][7:0] body;
    logic [1:0]      kind;
    logic [7:0]      status_error;
    logic [15:0]     read_value;
  } job_t;

endpackage

// ===== hdl/sbte_front.sv =====
// Front end: configuration registers, request classification and reply parsing.
// Depends on sbte_pkg; feeds at most one job per transaction into sbte_fifo.
module sbte_front #(
  parameter int RX_BUFFER_BYTES = sbte_pkg::RX_BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_accept,
  input  sbte_pkg::in_item_t in_item,
  output logic              job_push,
  output sbte_pkg::job_t    job
);

  localparam int CAP_INT = (RX_BUFFER_BYTES < 255) ? RX_BUFFER_BYTES : 255;
  localparam logic [8:0] REPLY_CAP = 9'(CAP_INT);

  logic [7:0]  read_opc_r, write_opc_r;
  logic [15:0] timeout_r;

  logic        awaiting_r,  awaiting_nxt;
  logic [7:0]  expected_r,  expected_nxt;
  logic [7:0]  taken_r,     taken_nxt;
  logic [7:0]  sum_r,       sum_nxt;
  logic        single_r,    single_nxt;
  logic [7:0]  err_r,       err_nxt;
  logic [15:0] val_r,       val_nxt;
  logic [15:0] idle_r,      idle_nxt;

  logic [8:0]  reply_len;
  logic [7:0]  sum_tmp;
  logic [7:0]  taken_tmp;
  logic        finish;
  logic [7:0]  fin_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_opc_r  <= sbte_pkg::READ_OPCODE_RST;
      write_opc_r <= sbte_pkg::WRITE_OPCODE_RST;
      timeout_r   <= sbte_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbte_pkg::CFG_READ_OPCODE:  read_opc_r  <= cfg_data[7:0];
        sbte_pkg::CFG_WRITE_OPCODE: write_opc_r <= cfg_data[7:0];
        sbte_pkg::CFG_TIMEOUT:      timeout_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      expected_r <= '0;
      taken_r    <= '0;
      sum_r      <= '0;
      single_r   <= 1'b0;
      err_r      <= '0;
      val_r      <= '0;
      idle_r     <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      expected_r <= expected_nxt;
      taken_r    <= taken_nxt;
      sum_r      <= sum_nxt;
      single_r   <= single_nxt;
      err_r      <= err_nxt;
      val_r      <= val_nxt;
      idle_r     <= idle_nxt;
    end
  end

  always_comb begin
    awaiting_nxt = awaiting_r;
    expected_nxt = expected_r;
    taken_nxt    = taken_r;
    sum_nxt      = sum_r;
    single_nxt   = single_r;
    err_nxt      = err_r;
    val_nxt      = val_r;
    idle_nxt     = idle_r;
    job_push     = 1'b0;
    job          = '0;
    finish       = 1'b0;
    fin_sum      = sum_r;
    reply_len    = {1'b0, in_item.read_len} + 9'd6;
    if (reply_len > REPLY_CAP) reply_len = REPLY_CAP;
    sum_tmp      = sum_r;
    taken_tmp    = taken_r + 8'd1;

    if (in_accept) begin
      case (in_item.op)
        sbte_pkg::OP_READ: begin
          awaiting_nxt = 1'b1;
          expected_nxt = reply_len[7:0];
          taken_nxt    = '0;
          sum_nxt      = '0;
          single_nxt   = (in_item.read_len <= 8'd1);
          err_nxt      = '0;
          val_nxt      = '0;
          idle_nxt     = '0;
          job_push     = 1'b1;
          job.kind     = sbte_pkg::KIND_TX;
          job.body     = {8'd0, in_item.read_len, in_item.reg_addr, read_opc_r,
                          8'd4, in_item.servo_id};
        end
        sbte_pkg::OP_WR_BYTE, sbte_pkg::OP_WR_WORD: begin
          awaiting_nxt    = 1'b0;
          idle_nxt        = '0;
          job_push        = 1'b1;
          job.kind        = sbte_pkg::KIND_TX;
          job.word_frame  = (in_item.op == sbte_pkg::OP_WR_WORD);
          job.body        = {in_item.write_value[15:8], in_item.write_value[7:0],
                             in_item.reg_addr, write_opc_r,
                             job.word_frame ? 8'd5 : 8'd4, in_item.servo_id};
        end
        sbte_pkg::OP_RX_BYTE: begin
          if (awaiting_r) begin
            idle_nxt = '0;
            // Skip anything before the first sync byte
            if (!(taken_r == 8'd0 && in_item.rx_byte != sbte_pkg::SYNC_BYTE)) begin
              if (taken_r >= 8'd2) sum_tmp = sum_r + in_item.rx_byte;
              sum_nxt = sum_tmp;
              if (taken_r == 8'd4) begin
                err_nxt = in_item.rx_byte;
              end else if (taken_r == 8'd5) begin
                val_nxt = {val_r[15:8], in_item.rx_byte};
              end else if (taken_r == 8'd6 && !single_r) begin
                val_nxt = {in_item.rx_byte, val_r[7:0]};
              end
              taken_nxt = taken_tmp;
              if (taken_tmp >= expected_r) begin
                finish  = 1'b1;
                fin_sum = sum_tmp;
              end
            end
          end
        end
        sbte_pkg::OP_IDLE_TICK: begin
          if (awaiting_r) begin
            if (idle_r >= timeout_r) begin
              finish  = 1'b1;
              fin_sum = sum_r;
            end else begin
              idle_nxt = idle_r + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end

    if (finish) begin
      awaiting_nxt  = 1'b0;
      idle_nxt      = '0;
      job_push      = 1'b1;
      job.is_result = 1'b1;
      if (fin_sum == sbte_pkg::SUM_GOOD) begin
        job.kind         = sbte_pkg::KIND_OK;
        job.status_error = err_nxt;
        job.read_value   = val_nxt;
      end else begin
        job.kind = sbte_pkg::KIND_FAIL;
      end
    end
  end

endmodule

// ===== hdl/sbte_fifo.sv =====
// Short job queue between front and back ends.
// Depends on sbte_pkg for the job type and depth.
module sbte_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbte_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sbte_pkg::job_t head_job
);

  localparam int DEPTH = sbte_pkg::JOB_Q_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  sbte_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    count_r;

  assign full       = (count_r == (PW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + (PW+1)'(1);
      else if (pop && !push) count_r <= count_r - (PW+1)'(1);
    end
  end

endmodule

// ===== hdl/sbte_back.sv =====
// Back end: expand queued jobs into result transactions, one per cycle unless the output stalls.
// Depends on sbte_pkg; drives the registered output channel.
module sbte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  sbte_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sbte_pkg::out_item_t out_data
);

  logic                out_valid_r;
  sbte_pkg::out_item_t out_data_r, out_data_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [3:0]          last_idx;
  logic [3:0]          body_idx;
  logic [7:0]          body_byte;
  logic                load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign last_idx  = head_job.word_frame ? 4'd8 : 4'd7;
  assign body_idx  = idx_r - 4'd2;

  always_comb begin
    case (body_idx)
      4'd0:    body_byte = head_job.body[0];
      4'd1:    body_byte = head_job.body[1];
      4'd2:    body_byte = head_job.body[2];
      4'd3:    body_byte = head_job.body[3];
      4'd4:    body_byte = head_job.body[4];
      4'd5:    body_byte = head_job.body[5];
      default: body_byte = '0;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    pop          = 1'b0;
    if (head_job.is_result) begin
      out_data_nxt.kind         = head_job.kind;
      out_data_nxt.status_error = head_job.status_error;
      out_data_nxt.read_value   = head_job.read_value;
      pop                       = load;
    end else begin
      out_data_nxt.kind = sbte_pkg::KIND_TX;
      if (idx_r < 4'd2) begin
        out_data_nxt.tx_byte = sbte_pkg::SYNC_BYTE;
        idx_nxt              = idx_r + 4'd1;
      end else if (idx_r < last_idx) begin
        out_data_nxt.tx_byte = body_byte;
        sum_nxt              = sum_r + body_byte;
        idx_nxt              = idx_r + 4'd1;
      end else begin
        // Checksum closes the frame
        out_data_nxt.tx_byte = ~sum_r;
        out_data_nxt.tx_last = 1'b1;
        idx_nxt              = '0;
        sum_nxt              = '0;
        pop                  = load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      sum_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_nxt;
        sum_r       <= sum_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/servo_bus_transaction_engine_top.sv =====
// Top level of the servo bus transaction engine: front end, job queue, back end.
// Depends on sbte_pkg, sbte_front, sbte_fifo and sbte_back.
//
// Host side of a half-duplex servo bus. Each input transaction is one event:
// a read request, a byte or word write request, a byte received from the bus,
// or an idle tick. The front end takes one transaction per clock whenever its
// four-entry job queue has room, updates the reply parser at once and queues at
// most one job. The back end drains the queue one output transaction per clock
// while the consumer is ready: a read request or byte write becomes an 8-byte
// frame, a word write a 9-byte frame, and a finished reply (complete, or cut
// short by timeout) one result. Sustained rate is therefore bounded by frame
// length at the back end. The output is registered, so a stalled consumer
// never blocks input until the queue fills. Configuration writes (cfg_index
// 0 read opcode, 1 write opcode, 2 timeout ticks; other indexes ignored) are
// always ready and must only be issued while the engine is idle. Reset is
// synchronous and active low.
module servo_bus_transaction_engine_top #(
  parameter int RX_BUFFER_BYTES = sbte_pkg::RX_BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbte_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbte_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic           q_full;
  logic           job_push;
  sbte_pkg::job_t job;
  logic           q_pop;
  logic           head_valid;
  sbte_pkg::job_t head_job;

  // Take configuration at any time; take input while the queue has room
  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  sbte_front #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_valid && in_ready),
    .in_item   (in_data),
    .job_push  (job_push),
    .job       (job)
  );

  sbte_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sbte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hdl/sbte_checker.sv =====
// Port-level checks for the servo bus transaction engine, bound to the top level.
// Depends on sbte_pkg and servo_bus_transaction_engine_top.
module sbte_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sbte_pkg::out_item_t out_data
);

  // Clear the output channel on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_last |-> out_data.kind == sbte_pkg::KIND_TX)
    else $error("tx_last on a non-transmit result");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == sbte_pkg::KIND_FAIL |->
      out_data.tx_byte == 8'd0 && out_data.status_error == 8'd0 &&
      out_data.read_value == 16'd0 && !out_data.tx_last)
    else $error("failed read carries data");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind == sbte_pkg::KIND_TX ||
      out_data.kind == sbte_pkg::KIND_OK || out_data.kind == sbte_pkg::KIND_FAIL)
    else $error("illegal result kind");

endmodule

bind servo_bus_transaction_engine_top sbte_checker u_sbte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/servo_bus_transaction_engine_top_tb.sv =====
// Self-checking testbench for servo_bus_transaction_engine_top:
// directed table, then random bus traffic. Depends on sbte_pkg and the engine RTL;
// expected frames and read results come from a local predictor.
module servo_bus_transaction_engine_top_tb;
  import sbte_pkg::*;

  // Opcode value outside the defined set; the engine must ignore it
  localparam logic [2:0] OP_UNDEFINED = 3'd7;
  // Register index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 300;   // long receiver stall that fills the job queue
  localparam int SETTLE_CYCLES = 40;    // four queued jobs of up to nine bytes each
  localparam int DRAIN_CYCLES  = 40;
  localparam int STUCK_LIMIT   = 4000;  // well above the hold-off and every pause
  localparam int PHASE_EVENTS  = 16;

  // One row of the directed table: a transaction and, where typed, the last result it causes
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predictor copy of the registers
  logic [7:0]  shadow_read_opcode;
  logic [7:0]  shadow_write_opcode;
  logic [15:0] shadow_timeout;

  // Predictor copy of the reply parser
  logic        reply_pending;
  int          reply_len_expected;
  logic [7:0]  reply_count;
  logic [7:0]  reply_sum;
  logic        reply_single;
  logic [7:0]  reply_err_byte;
  logic [15:0] reply_data;
  logic [15:0] tick_count;

  out_item_t bus_results_q[$];   // transmit bytes and read results not yet seen at the output
  int        mismatch_count;
  int        accepted_events;    // transactions that the engine acted on
  int        stuck_cycles;
  bit        no_idle;
  bit        hold_req;

  stim_row_t directed_rows [0:24];

  servo_bus_transaction_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void push_tx(input logic [7:0] b, input logic is_last);
    out_item_t r;
    r = '0;
    r.kind    = KIND_TX;
    r.tx_byte = b;
    r.tx_last = is_last;
    bus_results_q.push_back(r);
  endfunction

  // Frame: two sync bytes, the body, then the inverted low byte of the body sum
  function automatic void queue_frame(input logic [6:0][7:0] body, input int n);
    logic [7:0] sum;
    sum = 8'h00;
    push_tx(SYNC_BYTE, 1'b0);
    push_tx(SYNC_BYTE, 1'b0);
    for (int i = 0; i < n; i++) begin
      sum = sum + body[i];
      push_tx(body[i], 1'b0);
    end
    push_tx(~sum, 1'b1);
  endfunction

  // End of a read, complete or cut short: the sum decides pass or fail
  function automatic void close_reply();
    out_item_t r;
    r = '0;
    reply_pending = 1'b0;
    tick_count = '0;
    if (reply_sum == SUM_GOOD) begin
      r.kind         = KIND_OK;
      r.status_error = reply_err_byte;
      r.read_value   = reply_data;
    end else begin
      r.kind = KIND_FAIL;
    end
    bus_results_q.push_back(r);
  endfunction

  // Advance the predictor by one transaction; returns 0 when the engine ignores it
  function automatic bit predict_bus_event(input in_item_t t);
    logic [6:0][7:0] body;
    int n;
    bit acted;
    body = '0;
    n = 0;
    acted = 1'b1;
    case (t.op)
      OP_READ: begin
        // reply is len+6 bytes, capped at 255 (the 256-byte buffer never binds)
        reply_len_expected = (int'(t.read_len) + 6 > 255) ? 255 : int'(t.read_len) + 6;
        reply_pending  = 1'b1;
        reply_count    = '0;
        reply_sum      = '0;
        reply_single   = (t.read_len <= 8'd1);
        reply_err_byte = '0;
        reply_data     = '0;
        tick_count     = '0;
        body[0] = t.servo_id;
        body[1] = 8'd4;
        body[2] = shadow_read_opcode;
        body[3] = t.reg_addr;
        body[4] = t.read_len;
        n = 5;
      end
      OP_WR_BYTE, OP_WR_WORD: begin
        // any request drops a pending read without a result
        reply_pending = 1'b0;
        tick_count    = '0;
        body[0] = t.servo_id;
        body[1] = (t.op == OP_WR_BYTE) ? 8'd4 : 8'd5;
        body[2] = shadow_write_opcode;
        body[3] = t.reg_addr;
        body[4] = t.write_value[7:0];
        body[5] = t.write_value[15:8];
        n = (t.op == OP_WR_BYTE) ? 5 : 6;
      end
      OP_RX_BYTE: begin
        if (!reply_pending) begin
          acted = 1'b0;
        end else begin
          tick_count = '0;
          // skip noise until the first sync byte of the reply
          if (reply_count != 8'd0 || t.rx_byte == SYNC_BYTE) begin
            if (reply_count >= 8'd2) reply_sum = reply_sum + t.rx_byte;
            if (reply_count == 8'd4) reply_err_byte = t.rx_byte;
            else if (reply_count == 8'd5) reply_data[7:0] = t.rx_byte;
            else if (reply_count == 8'd6 && !reply_single) reply_data[15:8] = t.rx_byte;
            reply_count = reply_count + 8'd1;
            if (int'(reply_count) >= reply_len_expected) close_reply();
          end
        end
      end
      OP_IDLE_TICK: begin
        if (!reply_pending) acted = 1'b0;
        else if (tick_count >= shadow_timeout) close_reply();
        else tick_count = tick_count + 16'd1;
      end
      default: acted = 1'b0;
    endcase
    if (n > 0) queue_frame(body, n);
    return acted;
  endfunction

  // ---------------------------------------------------------------------------
  // Output checking and watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (bus_results_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected result: kind %0d tx %02h last %0b err %02h value %04h",
                 got.kind, got.tx_byte, got.tx_last, got.status_error, got.read_value);
      return;
    end
    want = bus_results_q.pop_front();
    if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
        got.tx_last !== want.tx_last || got.status_error !== want.status_error ||
        got.read_value !== want.read_value) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("result mismatch: expected kind %0d tx %02h last %0b err %02h value %04h,",
                 want.kind, want.tx_byte, want.tx_last, want.status_error, want.read_value,
                 " got kind %0d tx %02h last %0b err %02h value %04h",
                 got.kind, got.tx_byte, got.tx_last, got.status_error, got.read_value);
    end
  endfunction

  // Compare every accepted result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  // Abort when no channel has moved a transaction for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per result, no stalls in burst stretches, and one
  // long hold-off on request so the job queue fills and input backs up
  // ---------------------------------------------------------------------------

  initial begin
    int  stall;
    bit  holding;
    bit  held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!hold_req) held = 1'b0;
      holding = hold_req && !held;
      if (holding) stall = HOLD_CYCLES;
      else if (no_idle) stall = 0;
      else stall = $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      if (holding) held = 1'b1;
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one transaction; predict on acceptance. A typed row replaces the
  // last predicted result with the value written in the table.
  task automatic drive_txn(input in_item_t t, input bit typed, input out_item_t typed_res);
    int gap;
    int before_cnt;
    gap = (no_idle || hold_req) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    before_cnt = bus_results_q.size();
    if (predict_bus_event(t)) accepted_events++;
    if (typed && bus_results_q.size() > before_cnt) bus_results_q[$] = typed_res;
    @(negedge clk);
  endtask

  task automatic send_item(input in_item_t t);
    drive_txn(t, 1'b0, '0);
  endtask

  function automatic in_item_t rand_fields();
    in_item_t t;
    t.op          = 3'($urandom_range(0, 7));
    t.servo_id    = 8'($urandom_range(0, 255));
    t.reg_addr    = 8'($urandom_range(0, 255));
    t.read_len    = 8'($urandom_range(1, 249));
    t.write_value = 16'($urandom_range(0, 65535));
    t.rx_byte     = 8'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic in_item_t row_item(input logic [2:0] op, input logic [7:0] id,
                                        input logic [7:0] addr, input logic [7:0] len,
                                        input logic [15:0] value, input logic [7:0] rx);
    in_item_t t;
    t.op          = op;
    t.servo_id    = id;
    t.reg_addr    = addr;
    t.read_len    = len;
    t.write_value = value;
    t.rx_byte     = rx;
    return t;
  endfunction

  task automatic send_rx(input logic [7:0] b);
    in_item_t t;
    t = rand_fields();
    t.op = OP_RX_BYTE;
    t.rx_byte = b;
    send_item(t);
  endtask

  task automatic send_tick();
    in_item_t t;
    t = rand_fields();
    t.op = OP_IDLE_TICK;
    send_item(t);
  endtask

  task automatic send_write();
    in_item_t t;
    t = rand_fields();
    t.op = $urandom_range(0, 1) ? OP_WR_WORD : OP_WR_BYTE;
    send_item(t);
  endtask

  // Read request followed by a reply: mostly clean, sometimes with a flipped bit, cut short and
  // then idle ticks (timing out only when the timeout is at most 64), or cut short and dropped by a new request.
  // A negative length picks one at random, mostly small.
  task automatic exercise_read(input int len_req);
    logic [7:0] reply [0:254];
    logic [7:0] sum;
    in_item_t   t;
    int len, reply_bytes, cut, mode, pick;
    if (len_req >= 0) begin
      len = len_req;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) len = 0;
      else if (pick < 80) len = $urandom_range(1, 4);
      else if (pick < 95) len = $urandom_range(5, 12);
      else len = $urandom_range(13, 40);
    end
    t = rand_fields();
    t.op = OP_READ;
    t.read_len = 8'(len);
    send_item(t);

    reply_bytes = (len + 6 > 255) ? 255 : len + 6;
    reply[0] = SYNC_BYTE;
    reply[1] = SYNC_BYTE;
    reply[2] = t.servo_id;
    reply[3] = 8'(len + 2);
    reply[4] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
    for (int i = 5; i < reply_bytes - 1; i++) reply[i] = 8'($urandom_range(0, 255));
    sum = 8'h00;
    for (int i = 2; i < reply_bytes - 1; i++) sum = sum + reply[i];
    reply[reply_bytes - 1] = ~sum;

    mode = $urandom_range(0, 99);
    cut = reply_bytes;
    if (mode >= 70 && mode < 82)
      reply[$urandom_range(0, reply_bytes - 1)] ^= 8'(1 << $urandom_range(0, 7));
    else if (mode >= 82)
      cut = $urandom_range(0, reply_bytes - 1);

    // line noise ahead of the reply
    if ($urandom_range(0, 99) < 30)
      repeat ($urandom_range(1, 2)) send_rx(8'($urandom_range(0, 254)));

    for (int i = 0; i < cut; i++) begin
      // a lone tick between bytes never reaches a timeout
      if ($urandom_range(0, 99) < 8) send_tick();
      send_rx(reply[i]);
    end

    if (mode >= 82 && mode < 92) begin
      if (shadow_timeout <= 16'd64) repeat (int'(shadow_timeout) + 1) send_tick();
      else repeat (3) send_tick();
    end else if (mode >= 92) begin
      send_write();
    end
  endtask

  // Hold until every expected result is out and the job queue has drained, then write one register and its shadow copy
  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    in_valid <= 1'b0;
    while (bus_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_READ_OPCODE:  shadow_read_opcode  = value[7:0];
      CFG_WRITE_OPCODE: shadow_write_opcode = value[7:0];
      CFG_TIMEOUT:      shadow_timeout      = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] rd_op, input logic [7:0] wr_op,
                           input logic [15:0] ticks);
    write_register(CFG_READ_OPCODE, {8'h00, rd_op});
    write_register(CFG_WRITE_OPCODE, {8'h00, wr_op});
    write_register(CFG_TIMEOUT, ticks);
  endtask

  // Random traffic until enough acted-on transactions have gone in
  task automatic run_phase(input int events);
    in_item_t t;
    int target, pick;
    target = accepted_events + events;
    while (accepted_events < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        exercise_read(-1);
      end else if (pick < 85) begin
        send_write();
      end else begin
        t = rand_fields();
        t.op = 3'($urandom_range(3, 7));
        send_item(t);
      end
    end
    // close any open read so the next setting starts from an idle parser
    if (reply_pending) send_write();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_READ_OPCODE;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    accepted_events = 0;

    shadow_read_opcode  = READ_OPCODE_RST;
    shadow_write_opcode = WRITE_OPCODE_RST;
    shadow_timeout      = TIMEOUT_RST;
    reply_pending       = 1'b0;
    reply_len_expected  = 0;
    reply_count         = '0;
    reply_sum           = '0;
    reply_single        = 1'b0;
    reply_err_byte      = '0;
    reply_data          = '0;
    tick_count          = '0;

    // Traffic while idle and an undefined opcode: all ignored
    directed_rows[0]  = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h55), 1'b0, '0};
    directed_rows[1]  = '{row_item(OP_IDLE_TICK, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h00), 1'b0, '0};
    directed_rows[2]  = '{row_item(OP_UNDEFINED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF), 1'b0, '0};
    // Read one byte with reset opcodes; checksum byte CC ends the frame
    directed_rows[3]  = '{row_item(OP_READ, 8'h01, 8'h2B, 8'd1, 16'h0000, 8'h00), 1'b1,
                          '{KIND_TX, 8'hCC, 1'b1, 8'h00, 16'h0000}};
    // Noise byte skipped, then a clean seven-byte reply carrying 0x20
    directed_rows[4]  = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h00), 1'b0, '0};
    directed_rows[5]  = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'hFF), 1'b0, '0};
    directed_rows[6]  = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'hFF), 1'b0, '0};
    directed_rows[7]  = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h01), 1'b0, '0};
    directed_rows[8]  = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h03), 1'b0, '0};
    directed_rows[9]  = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h00), 1'b0, '0};
    directed_rows[10] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h20), 1'b0, '0};
    directed_rows[11] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'hDB), 1'b1,
                          '{KIND_OK, 8'h00, 1'b0, 8'h00, 16'h0020}};
    // Byte write ignores the high byte; word write with every field at its top
    directed_rows[12] = '{row_item(OP_WR_BYTE, 8'hFE, 8'h1E, 8'd0, 16'h1234, 8'h00), 1'b1,
                          '{KIND_TX, 8'hA8, 1'b1, 8'h00, 16'h0000}};
    directed_rows[13] = '{row_item(OP_WR_WORD, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'h00), 1'b1,
                          '{KIND_TX, 8'hFB, 1'b1, 8'h00, 16'h0000}};
    // Zero-length read, dropped by an over-long read, dropped in turn by a word read
    directed_rows[14] = '{row_item(OP_READ, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h00), 1'b0, '0};
    directed_rows[15] = '{row_item(OP_READ, 8'h05, 8'h24, 8'd255, 16'h0000, 8'h00), 1'b0, '0};
    directed_rows[16] = '{row_item(OP_READ, 8'h05, 8'h24, 8'd2, 16'h0000, 8'h00), 1'b0, '0};
    // Eight-byte reply with error byte 0x80 and a wrong checksum
    directed_rows[17] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'hFF), 1'b0, '0};
    directed_rows[18] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'hFF), 1'b0, '0};
    directed_rows[19] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h05), 1'b0, '0};
    directed_rows[20] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h04), 1'b0, '0};
    directed_rows[21] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h80), 1'b0, '0};
    directed_rows[22] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h34), 1'b0, '0};
    directed_rows[23] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h12), 1'b0, '0};
    directed_rows[24] = '{row_item(OP_RX_BYTE, 8'h00, 8'h00, 8'd0, 16'h0000, 8'h00), 1'b1,
                          '{KIND_FAIL, 8'h00, 1'b0, 8'h00, 16'h0000}};

    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table under reset settings
    foreach (directed_rows[i])
      drive_txn(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

    // Opcode extremes and a timeout of 1; poke the unused index once
    configure(8'h00, 8'hFF, 16'd1);
    write_register(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    run_phase(PHASE_EVENTS);

    // Opposite extremes and the longest timeout
    configure(8'hFF, 8'h00, 16'hFFFF);
    run_phase(PHASE_EVENTS);

    // Back-to-back stretch: neither side idles
    no_idle = 1'b1;
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              16'($urandom_range(2, 6)));
    run_phase(PHASE_EVENTS);
    no_idle = 1'b0;

    // Receiver holds off while the sender keeps offering, backing up the input
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd3);
    hold_req = 1'b1;
    run_phase(PHASE_EVENTS);
    hold_req = 1'b0;

    // Back to reset values
    configure(READ_OPCODE_RST, WRITE_OPCODE_RST, TIMEOUT_RST);
    run_phase(PHASE_EVENTS);

    // Random settings, one longest read, then random traffic
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              16'($urandom_range(1, 40)));
    exercise_read(249);
    run_phase(PHASE_EVENTS);

    // Drain and let the back end settle before the verdict
    in_valid <= 1'b0;
    while (bus_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && bus_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== servo_bus_transaction_engine_top.f =====
hdl/sbte_pkg.sv
hdl/sbte_front.sv
hdl/sbte_fifo.sv
hdl/sbte_back.sv
hdl/servo_bus_transaction_engine_top.sv
hdl/sbte_checker.sv
tb/servo_bus_transaction_engine_top_tb.sv
